[rtl/pdsm_pkg.sv]
package pdsm_pkg;

    // Port widths of the mixer
    localparam int MASK_W   = 15;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 4;

    // Largest magnitude of an output sample
    localparam logic [31:0] SAMPLE_MAX = 32'd32767;

    // Oscillator tuning: base pitch, sample rate, semitone ratio in Q31
    localparam logic [63:0] BASE_HZ      = 64'd440;
    localparam logic [63:0] SAMPLE_RATE  = 64'd44100;
    localparam logic [63:0] SEMITONE_Q31 = 64'd2275179671;

    // Quarter-wave polynomial coefficients (Q14)
    localparam logic [31:0] POLY_A = 32'd25736;
    localparam logic [31:0] POLY_B = 32'd10512;
    localparam logic [31:0] POLY_C = 32'd1160;

    // Operations of the shared add/subtract unit
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // Phase step of note idx for a phase word of pb bits (elaboration only)
    function automatic logic [63:0] step_value(input int idx, input int pb);
        logic [63:0] s;
        s = ((BASE_HZ << pb) + SAMPLE_RATE / 2) / SAMPLE_RATE;
        for (int k = 0; k < idx; k++) begin
            s = (s * SEMITONE_Q31 + (64'd1 << 30)) >> 31;
        end
        return s;
    endfunction

    // Sine of a 16-bit turn fraction, Q1.15 (elaboration only)
    function automatic logic signed [15:0] sine_of_turn(input logic [15:0] t);
        logic [31:0] r;
        logic [31:0] x;
        logic [31:0] x2;
        logic [31:0] p;
        logic [31:0] y;
        logic [31:0] mag;
        logic [15:0] m16;
        r   = {18'd0, t[13:0]};
        x   = t[14] ? (32'd16384 - r) : r;
        x2  = (x * x) >> 14;
        p   = POLY_B - ((x2 * POLY_C) >> 14);
        p   = POLY_A - ((x2 * p) >> 14);
        y   = (x * p) >> 14;
        if (y > 32'd16384) begin
            y = 32'd16384;
        end
        mag = (y * 32'd32767 + 32'd8192) >> 14;
        m16 = mag[15:0];
        return t[15] ? -m16 : m16;
    endfunction

endpackage

[rtl/pdsm_alu.sv]
module pdsm_alu #(
    parameter int W = 32
) (
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    input  pdsm_pkg::alu_op_t op,
    output logic [W-1:0]     result,
    output logic             carry
);
    import pdsm_pkg::*;

    logic [W:0] total;

    // carry out on subtract means a >= b (unsigned)
    assign total  = {1'b0, a} + {1'b0, (op == ALU_SUB) ? ~b : b}
                  + {{W{1'b0}}, (op == ALU_SUB)};
    assign result = total[W-1:0];
    assign carry  = total[W];

endmodule

[rtl/pdsm_sine_rom.sv]
module pdsm_sine_rom #(
    parameter int SINE_DEPTH = 1024,
    parameter int ADDR_W     = 10
) (
    input  logic                                 aclk,
    input  logic [ADDR_W-1:0]                    addr,
    output logic signed [pdsm_pkg::SAMPLE_W-1:0] data
);
    import pdsm_pkg::*;

    logic signed [SAMPLE_W-1:0] rom_mem [SINE_DEPTH];
    logic signed [SAMPLE_W-1:0] data_reg;

    for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_entry
        localparam int unsigned TURN = (g * 65536) / SINE_DEPTH;
        assign rom_mem[g] = sine_of_turn(16'(TURN));
    end

    always_ff @(posedge aclk) begin
        data_reg <= rom_mem[addr];
    end

    assign data = data_reg;

endmodule

[rtl/polyphonic_sine_note_mixer.sv]
// Polyphonic sine note mixer.
// Input channel (s_valid/s_ready/s_note_mask): one transaction per audio
// sample tick; bit i of the mask sounds note i (440 Hz and up in semitones).
// Output channel (m_valid/m_ready/m_sample/m_active_count): one transaction
// per input, the Q1.15 mix saturated to +-32767 and the number of notes mixed.
// One sequencer drives a shared add/subtract unit: phase advance, sum of
// sines, absolute value, rounding and a restoring divide by the note count.
// Per transaction: a scan step for each note, and for each active note an
// index step, a ROM read and an accumulate; then magnitude, rounding,
// MAG_W divide steps and the sign step. With no note sounding the
// sequencer goes straight from the scan to the sign step.
// s_ready is high only while the sequencer is idle. The result sits in an
// output register, so a new transaction is taken while it waits; if the
// next result is done before the receiver takes the previous one, the
// sequencer holds in its last step until the output register frees up.
// Reset (aresetn low, synchronous) zeroes all note phases and empties the
// output register.
module polyphonic_sine_note_mixer #(
    parameter int NOTES      = 15,
    parameter int SINE_DEPTH = 1024,
    parameter int PHASE_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [pdsm_pkg::MASK_W-1:0]          s_note_mask,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pdsm_pkg::SAMPLE_W-1:0] m_sample,
    output logic [pdsm_pkg::COUNT_W-1:0]         m_active_count
);
    import pdsm_pkg::*;

    // notes that the mask can reach
    localparam int SCAN   = (NOTES < MASK_W) ? NOTES : MASK_W;
    localparam int NOTE_W = (NOTES > 1) ? $clog2(NOTES) : 1;
    localparam int CNT_W  = $clog2(SCAN + 1);
    localparam int IDX_W  = $clog2(SINE_DEPTH);
    localparam int DEP_W  = $clog2(SINE_DEPTH + 1);
    // magnitude of the rounded sum, and the signed sum
    localparam int MAG_W  = $clog2(SCAN * 32767 + SCAN + 1);
    localparam int SUM_W  = MAG_W + 1;
    localparam int ALU_W  = (PHASE_BITS > SUM_W) ? PHASE_BITS : SUM_W;
    localparam int DCNT_W = $clog2(MAG_W);

    localparam logic [NOTE_W-1:0] LAST_NOTE = NOTE_W'(SCAN - 1);
    localparam logic [DCNT_W-1:0] LAST_DIV  = DCNT_W'(MAG_W - 1);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SCAN = 9'b000000010,  // test the mask bit of the current note
        ST_IDX  = 9'b000000100,  // ROM index from phase, advance phase
        ST_ROM  = 9'b000001000,  // ROM read
        ST_ACC  = 9'b000010000,  // add sine into the sum
        ST_ABS  = 9'b000100000,  // magnitude of the sum
        ST_RND  = 9'b001000000,  // add half the count
        ST_DIV  = 9'b010000000,  // one quotient bit per cycle
        ST_SIGN = 9'b100000000   // saturate, restore sign, load output
    } state_t;

    state_t state_reg, state_next;

    logic [MASK_W-1:0]     mask_reg;
    logic [NOTE_W-1:0]     note_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [DCNT_W-1:0]     div_cnt_reg;
    logic [PHASE_BITS-1:0] phase_reg [NOTES];
    logic [IDX_W-1:0]      idx_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic [MAG_W-1:0]      dq_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic                  neg_reg;
    logic                  m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    logic [PHASE_BITS-1:0] step_tab [NOTES];

    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    alu_op_t          alu_op;
    logic [ALU_W-1:0] alu_result;
    logic             alu_carry;

    logic signed [SAMPLE_W-1:0]   rom_data;
    logic [PHASE_BITS+DEP_W-1:0]  idx_prod;
    logic [CNT_W:0]               trial;
    logic [SAMPLE_W-2:0]          sat_q;
    logic                         s_fire;
    logic                         out_free;
    logic                         last_note;

    for (genvar g = 0; g < NOTES; g++) begin : g_step
        assign step_tab[g] = PHASE_BITS'(step_value(g, PHASE_BITS));
    end

    pdsm_alu #(
        .W (ALU_W)
    ) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .op     (alu_op),
        .result (alu_result),
        .carry  (alu_carry)
    );

    pdsm_sine_rom #(
        .SINE_DEPTH (SINE_DEPTH),
        .ADDR_W     (IDX_W)
    ) u_rom (
        .aclk (aclk),
        .addr (idx_reg),
        .data (rom_data)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_note = (note_reg == LAST_NOTE);

    // index = floor(phase * SINE_DEPTH / 2^PHASE_BITS)
    assign idx_prod = (PHASE_BITS + DEP_W)'(phase_reg[note_reg])
                    * (PHASE_BITS + DEP_W)'(SINE_DEPTH);

    assign trial = {rem_reg, dq_reg[MAG_W-1]};
    assign sat_q = (MAG_W'(SAMPLE_MAX) < dq_reg) ? (SAMPLE_W - 1)'(SAMPLE_MAX)
                                                  : dq_reg[SAMPLE_W-2:0];

    // shared unit operand selection
    always_comb begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;
        case (state_reg)
            ST_IDX: begin
                alu_a = ALU_W'(phase_reg[note_reg]);
                alu_b = ALU_W'(step_tab[note_reg]);
            end
            ST_ACC: begin
                alu_a = ALU_W'(acc_reg);
                alu_b = ALU_W'(rom_data);
            end
            ST_ABS: begin
                alu_b  = ALU_W'(acc_reg);
                alu_op = ALU_SUB;
            end
            ST_RND: begin
                alu_a = ALU_W'(dq_reg);
                alu_b = ALU_W'(n_reg >> 1);
            end
            ST_DIV: begin
                alu_a  = ALU_W'(trial);
                alu_b  = ALU_W'(n_reg);
                alu_op = ALU_SUB;
            end
            ST_SIGN: begin
                alu_b  = ALU_W'(sat_q);
                alu_op = neg_reg ? ALU_SUB : ALU_ADD;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (mask_reg[0]) begin
                    state_next = ST_IDX;
                end else if (last_note) begin
                    state_next = (n_reg == '0) ? ST_SIGN : ST_ABS;
                end
            end
            ST_IDX:  state_next = ST_ROM;
            ST_ROM:  state_next = ST_ACC;
            ST_ACC:  state_next = last_note ? ST_ABS : ST_SCAN;
            ST_ABS:  state_next = ST_RND;
            ST_RND:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_cnt_reg == LAST_DIV) state_next = ST_SIGN;
            end
            ST_SIGN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            note_reg    <= '0;
            n_reg       <= '0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < NOTES; k++) begin
                phase_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                note_reg <= '0;
                n_reg    <= '0;
            end
            if ((state_reg == ST_SCAN && !mask_reg[0] && !last_note) ||
                (state_reg == ST_ACC && !last_note)) begin
                note_reg <= note_reg + 1'b1;
            end
            if (state_reg == ST_ACC) begin
                n_reg <= n_reg + 1'b1;
            end
            if (state_reg == ST_IDX) begin
                phase_reg[note_reg] <= alu_result[PHASE_BITS-1:0];
            end
            if (state_reg == ST_RND) begin
                div_cnt_reg <= '0;
            end else if (state_reg == ST_DIV) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (state_reg == ST_SIGN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    mask_reg <= s_note_mask;
                    acc_reg  <= '0;
                    dq_reg   <= '0;
                    neg_reg  <= 1'b0;
                end
            end
            ST_SCAN: begin
                if (!mask_reg[0]) mask_reg <= mask_reg >> 1;
            end
            ST_IDX: begin
                idx_reg <= idx_prod[PHASE_BITS +: IDX_W];
            end
            ST_ACC: begin
                acc_reg  <= alu_result[SUM_W-1:0];
                mask_reg <= mask_reg >> 1;
            end
            ST_ABS: begin
                neg_reg <= acc_reg[SUM_W-1];
                dq_reg  <= acc_reg[SUM_W-1] ? alu_result[MAG_W-1:0]
                                            : acc_reg[MAG_W-1:0];
            end
            ST_RND: begin
                dq_reg  <= alu_result[MAG_W-1:0];
                rem_reg <= '0;
            end
            ST_DIV: begin
                rem_reg <= alu_carry ? alu_result[CNT_W-1:0] : trial[CNT_W-1:0];
                dq_reg  <= {dq_reg[MAG_W-2:0], alu_carry};
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_sample_reg <= alu_result[SAMPLE_W-1:0];
                    m_count_reg  <= COUNT_W'(n_reg);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_sample       = m_sample_reg;
    assign m_active_count = m_count_reg;

    a_onehot_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_rem_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < n_reg))
        else $error("divide remainder not below note count");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_active_count <= COUNT_W'(SCAN)))
        else $error("active count above scanned notes");

    a_silent_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_active_count == '0) |-> (m_sample == '0))
        else $error("nonzero sample with no notes");

    a_sample_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample != {1'b1, {(SAMPLE_W - 1){1'b0}}}))
        else $error("sample outside saturation range");

endmodule

[tb/sv/tb.sv]
typedef struct {
    logic signed [pdsm_pkg::SAMPLE_W-1:0] sample;
    logic [pdsm_pkg::COUNT_W-1:0]         count;
} mix_result_t;

class note_mix_board #(int NOTES = 15, int SINE_DEPTH = 1024, int PHASE_BITS = 32);
    logic [31:0] phase_acc[NOTES];
    logic [31:0] phase_step[NOTES];
    mix_result_t pending_mix[$];
    int          errors;

    function new();
        logic [63:0] s;
        s = ((pdsm_pkg::BASE_HZ << PHASE_BITS) + pdsm_pkg::SAMPLE_RATE / 2)
            / pdsm_pkg::SAMPLE_RATE;
        for (int i = 0; i < NOTES; i++) begin
            phase_step[i] = 32'(s) & phase_mask();
            phase_acc[i]  = '0;
            s = (s * pdsm_pkg::SEMITONE_Q31 + (64'd1 << 30)) >> 31;
        end
        errors = 0;
    endfunction

    function logic [31:0] phase_mask();
        return 32'((64'd1 << PHASE_BITS) - 64'd1);
    endfunction

    // quarter-wave polynomial sine, Q1.15
    function int sine_at(logic [31:0] ph);
        logic [63:0] idx;
        logic [31:0] t;
        logic [31:0] r;
        logic [31:0] x;
        logic [31:0] x2;
        logic [31:0] p;
        logic [31:0] y;
        logic [31:0] mag;
        idx = ({32'd0, ph} * 64'(SINE_DEPTH)) >> PHASE_BITS;
        t   = 32'(((idx << 16) / 64'(SINE_DEPTH)) & 64'hFFFF);
        r   = t & 32'h3FFF;
        x   = t[14] ? 32'd16384 - r : r;
        x2  = (x * x) >> 14;
        p   = pdsm_pkg::POLY_B - ((x2 * pdsm_pkg::POLY_C) >> 14);
        p   = pdsm_pkg::POLY_A - ((x2 * p) >> 14);
        y   = (x * p) >> 14;
        if (y > 32'd16384) begin
            y = 32'd16384;
        end
        mag = (y * 32'd32767 + 32'd8192) >> 14;
        return t[15] ? -int'(mag) : int'(mag);
    endfunction

    // one accepted sample tick: mix the sounding notes, advance their phases
    function void note_tick(logic [pdsm_pkg::MASK_W-1:0] mask);
        longint      sum;
        longint      q;
        int          n;
        mix_result_t r;
        sum = 0;
        n   = 0;
        for (int i = 0; i < NOTES && i < pdsm_pkg::MASK_W; i++) begin
            if (mask[i]) begin
                sum += sine_at(phase_acc[i]);
                phase_acc[i] = (phase_acc[i] + phase_step[i]) & phase_mask();
                n++;
            end
        end
        r.sample = '0;
        if (n != 0) begin
            q = ((sum < 0 ? -sum : sum) + n / 2) / n;
            if (q > longint'(pdsm_pkg::SAMPLE_MAX)) begin
                q = longint'(pdsm_pkg::SAMPLE_MAX);
            end
            r.sample = pdsm_pkg::SAMPLE_W'((sum < 0) ? -q : q);
        end
        r.count = 4'(n);
        pending_mix.push_back(r);
    endfunction

    function void check_result(logic signed [pdsm_pkg::SAMPLE_W-1:0] sample,
                               logic [pdsm_pkg::COUNT_W-1:0] count);
        mix_result_t want;
        if (pending_mix.size() == 0) begin
            $display("%0t: result with none pending: sample %0d count %0d",
                     $time, sample, count);
            errors++;
            return;
        end
        want = pending_mix.pop_front();
        if (sample !== want.sample || count !== want.count) begin
            $display("%0t: mismatch: expected sample %0d count %0d, actual sample %0d count %0d",
                     $time, want.sample, want.count, sample, count);
            errors++;
        end
    endfunction

    function int outstanding();
        return pending_mix.size();
    endfunction
endclass

module tb;
    localparam int NOTES        = 15;
    localparam int SINE_DEPTH   = 1024;
    localparam int PHASE_BITS   = 32;
    localparam int RANDOM_TICKS = 480;
    // longer than the worst transaction inside the mixer; leave margin after drain
    localparam int DRAIN_CYCLES = 150;
    // ~500 transactions, each with busy time, a sender gap and a long stall, with plenty of slack
    localparam int CYCLE_LIMIT  = 400000;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 s_valid;
    logic                                 s_ready;
    logic [pdsm_pkg::MASK_W-1:0]          s_note_mask;
    logic                                 m_valid;
    logic                                 m_ready;
    logic signed [pdsm_pkg::SAMPLE_W-1:0] m_sample;
    logic [pdsm_pkg::COUNT_W-1:0]         m_active_count;

    note_mix_board #(NOTES, SINE_DEPTH, PHASE_BITS) board;

    int cycle_count = 0;
    int burst_left  = 0;
    int rx_left     = 0;
    int rx_mode     = 0;

    polyphonic_sine_note_mixer #(
        .NOTES      (NOTES),
        .SINE_DEPTH (SINE_DEPTH),
        .PHASE_BITS (PHASE_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_note_mask    (s_note_mask),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample       (m_sample),
        .m_active_count (m_active_count)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Monitor. Both channels are sampled at the edge, so values seen are the
    // ones the mixer saw; a transaction is counted when valid and ready are high.
    // An input is always noted before a result popped in the same cycle, which
    // is harmless: a result never belongs to an input taken at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.note_tick(s_note_mask);
            end
            if (m_valid && m_ready) begin
                board.check_result(m_sample, m_active_count);
            end
        end
    end

    // Receiver backpressure. Modes change at random intervals:
    // always ready, coin flip, fixed 1-in-5 pattern, and mostly stalled.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 300);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (cycle_count % 5 == 0);
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Offer one sample tick and hold it until taken. The sender runs in bursts;
    // at the end of a burst valid drops for a random gap while the mask wiggles
    // with junk so that payload under a low valid is exercised too.
    task automatic send_tick(input logic [pdsm_pkg::MASK_W-1:0] mask);
        int gap;
        s_valid     <= 1'b1;
        s_note_mask <= mask;
        do @(posedge aclk); while (!s_ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap        = $urandom_range(1, 24);
            s_valid   <= 1'b0;
            repeat (gap) begin
                s_note_mask <= pdsm_pkg::MASK_W'($urandom);
                @(posedge aclk);
            end
        end
    endtask

    initial begin
        logic [pdsm_pkg::MASK_W-1:0] chord;
        int                          hold_left;

        board       = new();
        hold_left   = 0;
        chord       = '0;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_note_mask <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: silence, full chord, every note alone, alternating sets.
        send_tick(15'h0000);
        send_tick(15'h7FFF);
        for (int i = 0; i < pdsm_pkg::MASK_W; i++) begin
            send_tick(15'(1 << i));
        end
        send_tick(15'h5555);
        send_tick(15'h2AAA);
        send_tick(15'h0000);
        send_tick(15'h7FFF);

        // Random: mostly held chords so phases sweep through whole turns,
        // with sparse, dense and silent ticks dropped in as noise.
        for (int k = 0; k < RANDOM_TICKS; k++) begin
            if (hold_left == 0) begin
                hold_left = $urandom_range(1, 24);
                case ($urandom_range(0, 4))
                    0: chord = pdsm_pkg::MASK_W'($urandom);
                    1: chord = 15'(1 << $urandom_range(0, 14))
                             | 15'(1 << $urandom_range(0, 14));
                    2: chord = 15'h7FFF & ~15'(1 << $urandom_range(0, 14));
                    3: chord = 15'h7FFF;
                    default: chord = pdsm_pkg::MASK_W'($urandom & $urandom);
                endcase
            end
            hold_left--;
            if ($urandom_range(0, 9) == 0) begin
                send_tick($urandom_range(0, 1) ? 15'h0000 : pdsm_pkg::MASK_W'($urandom));
            end else begin
                send_tick(chord);
            end
        end
        s_valid <= 1'b0;

        // Drain, then give the mixer time to show any stray transaction.
        while (board.outstanding() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/pdsm_pkg.sv
rtl/pdsm_alu.sv
rtl/pdsm_sine_rom.sv
rtl/polyphonic_sine_note_mixer.sv
tb/sv/tb.sv
